// File: hdl/bmprle_pkg.sv
package bmprle_pkg;

    // Largest image side in pixels; register values above it are clamped.
    localparam int MAX_SIDE  = 4096;
    localparam int SIDE_W    = 13;
    localparam int COL_W     = 16;
    localparam int ROW_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    // Result kinds.
    localparam logic [1:0] K_RUN = 2'd0;
    localparam logic [1:0] K_EOL = 2'd1;
    localparam logic [1:0] K_EOB = 2'd2;
    localparam logic [1:0] K_ERR = 2'd3;

    // Escape codes of the RLE8 format.
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef enum logic [2:0] {
        PH_CODE,
        PH_VALUE,
        PH_ESC,
        PH_DX,
        PH_DY,
        PH_LIT,
        PH_PAD
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] run_length;
        logic [BYTE_W-1:0] pixel_value;
    } t_out_item;

    typedef struct packed {
        logic advance;
        logic rearm;
    } t_step_ctl;

    typedef struct packed {
        logic      emit;
        t_out_item result;
    } t_step_res;

endpackage

// File: hdl/bmprle_core.sv
module bmprle_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bmprle_pkg::t_step_ctl             i_ctl,
    input  bmprle_pkg::t_in_item              i_item,
    input  logic [bmprle_pkg::SIDE_W-1:0]     i_width,
    input  logic [bmprle_pkg::SIDE_W-1:0]     i_height,
    output bmprle_pkg::t_step_res             o_step
);
    import bmprle_pkg::*;

    t_phase              r_phase, n_phase;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [BYTE_W-1:0]   r_pend, n_pend;
    logic                r_odd, n_odd;
    logic                r_finished, n_finished;

    logic [SIDE_W-1:0]   w_eff;
    logic [SIDE_W-1:0]   h_eff;
    logic [COL_W:0]      run_sum;
    logic [COL_W:0]      dx_sum;
    logic [COL_W:0]      one_sum;
    logic [COL_W-1:0]    run_col;
    logic [COL_W-1:0]    dx_col;
    logic [COL_W-1:0]    one_col;
    logic [SIDE_W-1:0]   eol_row;
    logic [SIDE_W-1:0]   dy_row;
    logic                dx_bad;
    logic                dy_bad;
    logic                eol_last;
    logic [BYTE_W-1:0]   pend_dec;
    logic [BYTE_W-1:0]   b;
    logic                eod;

    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_MAX) begin
            r = SIDE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign b        = i_item.data_byte;
    assign eod      = i_item.end_of_data;
    assign w_eff    = eff_side(i_width);
    assign h_eff    = eff_side(i_height);

    // Column arithmetic saturates at the top of the 16-bit range.
    assign run_sum  = {1'b0, r_col} + {{(COL_W+1-BYTE_W){1'b0}}, r_pend};
    assign dx_sum   = {1'b0, r_col} + {{(COL_W+1-BYTE_W){1'b0}}, b};
    assign one_sum  = {1'b0, r_col} + (COL_W+1)'(1);
    assign run_col  = run_sum[COL_W] ? '1 : run_sum[COL_W-1:0];
    assign dx_col   = dx_sum[COL_W] ? '1 : dx_sum[COL_W-1:0];
    assign one_col  = one_sum[COL_W] ? '1 : one_sum[COL_W-1:0];

    assign eol_row  = {1'b0, r_row} + SIDE_W'(1);
    assign dy_row   = {1'b0, r_row} + {{(SIDE_W-BYTE_W){1'b0}}, b};
    assign eol_last = eol_row >= h_eff;
    assign dx_bad   = dx_col >= {{(COL_W-SIDE_W){1'b0}}, w_eff};
    assign dy_bad   = dy_row >= h_eff;
    assign pend_dec = r_pend - BYTE_W'(1);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (!r_finished && !eod) begin
            unique case (r_phase)
                PH_CODE:  n_phase = (b == ESC_EOL) ? PH_ESC : PH_VALUE;
                PH_VALUE: n_phase = PH_CODE;
                PH_ESC: begin
                    if (b == ESC_EOL) begin
                        n_phase = PH_CODE;
                    end else if (b == ESC_DELTA) begin
                        n_phase = PH_DX;
                    end else if (b != ESC_EOB) begin
                        n_phase = PH_LIT;
                    end
                end
                PH_DX:    n_phase = dx_bad ? PH_DX : PH_DY;
                PH_DY:    n_phase = dy_bad ? PH_DY : PH_CODE;
                PH_LIT: begin
                    if (pend_dec == '0) begin
                        n_phase = r_odd ? PH_PAD : PH_CODE;
                    end
                end
                PH_PAD:   n_phase = PH_CODE;
                default:  n_phase = PH_CODE;
            endcase
        end
    end

    // Datapath and result.
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_pend     = r_pend;
        n_odd      = r_odd;
        n_finished = r_finished;
        o_step     = '0;
        if (!r_finished) begin
            if (eod) begin
                o_step.emit        = 1'b1;
                o_step.result.kind = (r_phase inside {PH_CODE, PH_PAD}) ? K_EOB : K_ERR;
                n_finished         = 1'b1;
            end else begin
                case (r_phase)
                    PH_CODE: begin
                        if (b != ESC_EOL) begin
                            n_pend = b;
                        end
                    end
                    PH_VALUE: begin
                        o_step.emit               = 1'b1;
                        o_step.result.kind        = K_RUN;
                        o_step.result.column      = r_col;
                        o_step.result.row         = r_row;
                        o_step.result.run_length  = r_pend;
                        o_step.result.pixel_value = b;
                        n_col                     = run_col;
                    end
                    PH_ESC: begin
                        if (b == ESC_EOL) begin
                            n_col              = '0;
                            n_row              = eol_row[ROW_W-1:0];
                            o_step.emit        = 1'b1;
                            o_step.result.kind = eol_last ? K_EOB : K_EOL;
                            n_finished         = eol_last;
                        end else if (b == ESC_EOB) begin
                            o_step.emit        = 1'b1;
                            o_step.result.kind = K_EOB;
                            n_finished         = 1'b1;
                        end else if (b != ESC_DELTA) begin
                            n_pend = b;
                            n_odd  = b[0];
                        end
                    end
                    PH_DX: begin
                        n_col = dx_col;
                        if (dx_bad) begin
                            o_step.emit        = 1'b1;
                            o_step.result.kind = K_ERR;
                            n_finished         = 1'b1;
                        end
                    end
                    PH_DY: begin
                        n_row = dy_row[ROW_W-1:0];
                        if (dy_bad) begin
                            o_step.emit        = 1'b1;
                            o_step.result.kind = K_ERR;
                            n_finished         = 1'b1;
                        end
                    end
                    PH_LIT: begin
                        o_step.emit               = 1'b1;
                        o_step.result.kind        = K_RUN;
                        o_step.result.column      = r_col;
                        o_step.result.row         = r_row;
                        o_step.result.run_length  = BYTE_W'(1);
                        o_step.result.pixel_value = b;
                        n_col                     = one_col;
                        n_pend                    = pend_dec;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.rearm) begin
            r_phase    <= PH_CODE;
            r_col      <= '0;
            r_row      <= '0;
            r_pend     <= '0;
            r_odd      <= 1'b0;
            r_finished <= 1'b0;
        end else if (i_ctl.advance) begin
            r_phase    <= n_phase;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pend     <= n_pend;
            r_odd      <= n_odd;
            r_finished <= n_finished;
        end
    end

    a_quiet_when_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !o_step.emit)
        else $error("result produced after the stream was finished");

    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rearm |=> (r_phase == PH_CODE) && !r_finished && (r_col == '0))
        else $error("decoder not rearmed after a configuration write");

    a_row_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> ({1'b0, r_row} < h_eff))
        else $error("active row counter has reached the image height");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE || r_phase == PH_LIT) |-> (r_pend != '0))
        else $error("pending pixel count is zero inside a run or literal block");

endmodule

// File: hdl/bmp_rle8_decoder.sv
// BMP RLE8 run-length decoder.
// Compressed bytes arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_data); a transaction with end_of_data set marks the end of the stream and
// carries no byte. Pixel-run writes, line ends, bitmap end and errors leave on the
// output channel (o_out_valid / i_out_ready, payload o_out_data), at most one per
// input transaction. Width and height are written through the configuration
// channel (i_cfg_valid / o_cfg_ready, index and data); any write to a known
// register restarts decoding at the bottom-left corner. Writes are taken every
// cycle and should only be issued while the decoder is idle.
// An accepted byte is held in the input register; its state update and result are
// computed from there and registered in the output register once that register is
// free. One byte is taken every cycle while the receiver keeps up, limited by the
// combinational state update between the two registers.
// When the receiver stalls, the result waits in the output register and one more
// byte is held in the input register before o_in_ready falls.
// Reset is synchronous: both registers are emptied, width and height return to
// 256 and the decoder waits for the first byte of a code. No clearing pass is
// needed. After bitmap end or an error, further bytes are accepted silently.
module bmp_rle8_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bmprle_pkg::t_in_item               i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bmprle_pkg::t_out_item              o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmprle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bmprle_pkg::SIDE_W-1:0]      i_cfg_data
);
    import bmprle_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [SIDE_W-1:0] r_width;
    logic [SIDE_W-1:0] r_height;

    logic              advance;
    logic              cfg_write;
    logic              cfg_known;
    t_step_ctl         ctl;
    t_step_res         step;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        unique case (i_cfg_index)
            CFG_WIDTH, CFG_HEIGHT: cfg_known = 1'b1;
            default:               cfg_known = 1'b0;
        endcase
    end

    assign ctl.advance = advance;
    assign ctl.rearm   = cfg_write && cfg_known;

    bmprle_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (r_in),
        .i_width  (r_width),
        .i_height (r_height),
        .o_step   (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= SIDE_RST;
            r_height    <= SIDE_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step.emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write && i_cfg_index == CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (cfg_write && i_cfg_index == CFG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance && step.emit) begin
            r_out <= step.result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bmprle_pkg::*;

    // Index past the listed registers: a write there must leave the decoder alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIDE_W-1:0]    i_cfg_data = '0;

    bmp_rle8_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Decoder state as the testbench sees it.
    logic [SIDE_W-1:0] cfg_width;
    logic [SIDE_W-1:0] cfg_height;
    t_phase            m_phase;
    int unsigned       m_col;
    int unsigned       m_row;
    int unsigned       m_count;
    bit                m_odd;
    bit                m_done;

    t_in_item  byte_q[$];
    t_out_item pending_writes[$];
    t_out_item want;

    int n_stream = 0;
    int n_images = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_bad = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int gap_left = 0;
    int rcv_tick = 0;
    logic [15:0] stall_pat = '1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    function automatic int unsigned eff_side(logic [SIDE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    function automatic int unsigned col_sum(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > 65535) ? 65535 : s;
    endfunction

    function automatic void restart_decode();
        m_phase = PH_CODE;
        m_col   = 0;
        m_row   = 0;
        m_count = 0;
        m_odd   = 1'b0;
        m_done  = 1'b0;
    endfunction

    function automatic t_out_item pixel_write(int unsigned len, int unsigned val);
        t_out_item r;
        r             = '0;
        r.kind        = K_RUN;
        r.column      = m_col[COL_W-1:0];
        r.row         = m_row[ROW_W-1:0];
        r.run_length  = len[BYTE_W-1:0];
        r.pixel_value = val[BYTE_W-1:0];
        return r;
    endfunction

    // Advances the decoder state by one byte and queues the write it produces.
    function automatic void decode_byte(t_in_item it);
        int unsigned w;
        int unsigned h;
        int unsigned b;
        t_out_item   r;
        bit          fire;
        w    = eff_side(cfg_width);
        h    = eff_side(cfg_height);
        b    = it.data_byte;
        r    = '0;
        fire = 1'b0;
        if (m_done) return;
        if (it.end_of_data) begin
            r.kind = (m_phase == PH_CODE || m_phase == PH_PAD) ? K_EOB : K_ERR;
            fire   = 1'b1;
        end else begin
            case (m_phase)
                PH_CODE: begin
                    if (b == ESC_EOL) begin
                        m_phase = PH_ESC;
                    end else begin
                        m_count = b;
                        m_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    r       = pixel_write(m_count, b);
                    fire    = 1'b1;
                    m_col   = col_sum(m_col, m_count);
                    m_phase = PH_CODE;
                end
                PH_ESC: begin
                    if (b == ESC_EOL) begin
                        m_col   = 0;
                        m_row   = m_row + 1;
                        m_phase = PH_CODE;
                        r.kind  = (m_row >= h) ? K_EOB : K_EOL;
                        fire    = 1'b1;
                    end else if (b == ESC_EOB) begin
                        r.kind = K_EOB;
                        fire   = 1'b1;
                    end else if (b == ESC_DELTA) begin
                        m_phase = PH_DX;
                    end else begin
                        m_count = b;
                        m_odd   = b[0];
                        m_phase = PH_LIT;
                    end
                end
                PH_DX: begin
                    m_col = col_sum(m_col, b);
                    if (m_col >= w) begin
                        r.kind = K_ERR;
                        fire   = 1'b1;
                    end else begin
                        m_phase = PH_DY;
                    end
                end
                PH_DY: begin
                    m_row = m_row + b;
                    if (m_row >= h) begin
                        r.kind = K_ERR;
                        fire   = 1'b1;
                    end else begin
                        m_phase = PH_CODE;
                    end
                end
                PH_LIT: begin
                    r       = pixel_write(1, b);
                    fire    = 1'b1;
                    m_col   = col_sum(m_col, 1);
                    m_count = (m_count - 1) & 8'hFF;
                    if (m_count == 0) m_phase = m_odd ? PH_PAD : PH_CODE;
                end
                default: begin
                    m_phase = PH_CODE;
                end
            endcase
        end
        if (fire) begin
            if (r.kind == K_EOB || r.kind == K_ERR) m_done = 1'b1;
            pending_writes.push_back(r);
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_in_data);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || byte_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= byte_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: ready follows a random 16-bit pattern that is redrawn periodically.
    always @(posedge i_clk) begin
        rcv_tick++;
        if (rcv_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = '1;
                1: stall_pat = 16'($urandom);
                2: stall_pat = 16'($urandom | $urandom);
                default: stall_pat = 16'($urandom & $urandom);
            endcase
            if (stall_pat == 0) stall_pat = 16'h0001;
        end
        i_out_ready <= stall_pat[rcv_tick % 16] && !(hold_req && !hold_done);
    end

    // Long hold-off on the output side so that the decoder backs up into its input.
    initial begin
        wait (hold_req);
        repeat (300) @(posedge i_clk);
        hold_done <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            kind_seen[o_out_data.kind]++;
            if (pending_writes.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("%0t: result with nothing expected: kind %0d col %0d row %0d len %0d val %0d",
                             $time, o_out_data.kind, o_out_data.column, o_out_data.row,
                             o_out_data.run_length, o_out_data.pixel_value);
                end
            end else begin
                want = pending_writes.pop_front();
                if (o_out_data.kind !== want.kind || o_out_data.column !== want.column ||
                    o_out_data.row !== want.row || o_out_data.run_length !== want.run_length ||
                    o_out_data.pixel_value !== want.pixel_value) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("%0t: expected kind %0d col %0d row %0d len %0d val %0d",
                                 $time, want.kind, want.column, want.row, want.run_length,
                                 want.pixel_value);
                        $display("%0t:      got kind %0d col %0d row %0d len %0d val %0d",
                                 $time, o_out_data.kind, o_out_data.column, o_out_data.row,
                                 o_out_data.run_length, o_out_data.pixel_value);
                    end
                end
            end
        end
    end

    task automatic put(input int unsigned b);
        t_in_item it;
        it.data_byte   = b[BYTE_W-1:0];
        it.end_of_data = 1'b0;
        byte_q.push_back(it);
        n_stream++;
    endtask

    task automatic put_end();
        t_in_item it;
        it.data_byte   = BYTE_W'($urandom_range(0, 255));
        it.end_of_data = 1'b1;
        byte_q.push_back(it);
        n_stream++;
    endtask

    // Waits until every byte is taken and every write has come back, then lets
    // the pipeline settle for bytes that give no result.
    task automatic drain();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || pending_writes.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) begin
            cfg_width = val;
            restart_decode();
        end else if (idx == CFG_HEIGHT) begin
            cfg_height = val;
            restart_decode();
        end
        @(negedge i_clk);
    endtask

    // One image with random content, ended in one of several ways, some of them errors.
    task automatic stream_image(input int n_codes);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned c;
        int unsigned lim;
        bit          ended;
        w     = eff_side(cfg_width);
        h     = eff_side(cfg_height);
        col   = 0;
        row   = 0;
        ended = 1'b0;
        for (int k = 0; k < n_codes && !ended; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    c = $urandom_range(1, 255);
                    put(c);
                    put($urandom_range(0, 255));
                    col = col_sum(col, c);
                end
                4, 5, 6: begin
                    c = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255)
                                                     : $urandom_range(3, 12);
                    put(0);
                    put(c);
                    repeat (c) put($urandom_range(0, 255));
                    if (c[0]) put($urandom_range(0, 255));
                    col = col_sum(col, c);
                end
                7, 8: begin
                    put(0);
                    put(ESC_EOL);
                    col = 0;
                    row++;
                    if (row >= h) ended = 1'b1;
                end
                default: begin
                    // Mostly in-range offsets; now and then one that overshoots.
                    put(0);
                    put(ESC_DELTA);
                    lim = (col < w) ? w - 1 - col : 255;
                    if (lim > 255 || $urandom_range(0, 9) == 0) lim = 255;
                    c = $urandom_range(0, lim);
                    put(c);
                    col = col_sum(col, c);
                    if (col >= w) begin
                        ended = 1'b1;
                    end else begin
                        lim = h - 1 - row;
                        if (lim > 255 || $urandom_range(0, 9) == 0) lim = 255;
                        c = $urandom_range(0, lim);
                        put(c);
                        row = row + c;
                        if (row >= h) ended = 1'b1;
                    end
                end
            endcase
        end
        if (!ended) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    put(0);
                    put(ESC_EOB);
                end
                4, 5: put_end();
                6: begin
                    // Stream cut off part way through a code.
                    case ($urandom_range(0, 4))
                        0: put($urandom_range(1, 255));
                        1: put(0);
                        2: begin
                            put(0);
                            put(ESC_DELTA);
                        end
                        3: begin
                            put(0);
                            put(ESC_DELTA);
                            put(0);
                        end
                        default: begin
                            c = $urandom_range(3, 20);
                            put(0);
                            put(c);
                            repeat ($urandom_range(0, c - 1)) put($urandom_range(0, 255));
                        end
                    endcase
                    put_end();
                end
                default: ;
            endcase
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put($urandom_range(0, 255));
    endtask

    initial begin
        cfg_width  = SIDE_RST;
        cfg_height = SIDE_RST;
        restart_decode();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset-size image: shortest and longest runs, an odd literal with its pad,
        // a line end, a delta, an explicit end; the bytes after the end are dropped.
        put(1);
        put(0);
        put(255);
        put(255);
        put(0);
        put(3);
        put(8'h5A);
        put(8'hA5);
        put(8'h0F);
        put(8'hF0);
        put(0);
        put(ESC_EOL);
        put(0);
        put(ESC_DELTA);
        put(5);
        put(1);
        put(0);
        put(ESC_EOB);
        put(8'h80);
        put_end();
        drain();

        // Zero width behaves as one column; a line end on the only row ends the bitmap.
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, SIDE_W'(1));
        put(0);
        put(ESC_EOL);
        drain();

        // Vertical offset that leaves the image.
        write_reg(CFG_HEIGHT, SIDE_W'(2));
        put(0);
        put(ESC_DELTA);
        put(0);
        put(2);
        drain();

        // Horizontal offset that leaves the image.
        write_reg(CFG_WIDTH, SIDE_W'(4));
        put(0);
        put(ESC_DELTA);
        put(4);
        drain();

        // The spare index must not rearm the decoder, so this end code stays silent.
        write_reg(CFG_SPARE, '1);
        put(0);
        put(ESC_EOB);
        drain();

        // Oversized width is clamped; the stream stops cleanly between codes.
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, SIDE_MAX);
        put_end();
        drain();

        // One very long row drives the column into saturation, with the receiver
        // held off at the start so that the input side backs up.
        write_reg(CFG_WIDTH, SIDE_MAX);
        write_reg(CFG_HEIGHT, SIDE_W'(4));
        hold_req = 1'b1;
        repeat (260) begin
            put(255);
            put($urandom_range(0, 255));
        end
        put(0);
        put(3);
        repeat (4) put($urandom_range(0, 255));
        put(0);
        put(ESC_DELTA);
        put(1);
        n_images = 7;

        while (n_stream < 1550) begin
            drain();
            case ($urandom_range(0, 7))
                0: write_reg(CFG_WIDTH, '0);
                1: write_reg(CFG_WIDTH, '1);
                2: write_reg(CFG_WIDTH, SIDE_MAX);
                3: write_reg(CFG_WIDTH, SIDE_W'($urandom_range(1, 16)));
                4: write_reg(CFG_WIDTH, SIDE_W'($urandom_range(1, 4096)));
                5: write_reg(CFG_WIDTH, SIDE_W'($urandom));
                6: write_reg(CFG_WIDTH, SIDE_RST);
                default: write_reg(CFG_WIDTH, SIDE_W'($urandom_range(17, 600)));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(CFG_HEIGHT, '0);
                1: write_reg(CFG_HEIGHT, '1);
                2: write_reg(CFG_HEIGHT, SIDE_MAX);
                3, 4, 5: write_reg(CFG_HEIGHT, SIDE_W'($urandom_range(1, 4)));
                6: write_reg(CFG_HEIGHT, SIDE_W'($urandom_range(5, 40)));
                default: write_reg(CFG_HEIGHT, SIDE_W'($urandom));
            endcase
            n_images++;
            if ($urandom_range(0, 9) == 0) begin
                // Raw noise, with the occasional end-of-stream marker thrown in.
                repeat ($urandom_range(20, 60)) begin
                    if ($urandom_range(0, 15) == 0) put_end();
                    else put($urandom_range(0, 255));
                end
            end else begin
                stream_image($urandom_range(2, 30));
            end
        end
        drain();

        $display("%0d bytes taken over %0d images; %0d results checked", n_accepted, n_images,
                 n_results);
        $display("runs %0d, line ends %0d, bitmap ends %0d, errors %0d", kind_seen[K_RUN],
                 kind_seen[K_EOL], kind_seen[K_EOB], kind_seen[K_ERR]);
        if (n_bad == 0 && pending_writes.size() == 0) begin
            $display("bmp_rle8_decoder: match");
        end else begin
            $display("%0d bad results, %0d still outstanding", n_bad, pending_writes.size());
            $display("bmp_rle8_decoder: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timed out with %0d bytes queued and %0d results outstanding", byte_q.size(),
                 pending_writes.size());
        $display("bmp_rle8_decoder: mismatch");
        $finish;
    end

endmodule
